// ===== sv/snu_pkg.sv =====
// ----------------------------------------------------------------------------
// snu_pkg
// Shared widths, fixed-point constants, register codes and item types for
// the spiking neuron update unit.
// ----------------------------------------------------------------------------
package snu_pkg;

  // field widths
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned V_W        = 20;
  localparam int unsigned TR_W       = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned NE_W       = 11;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;

  // default neuron count
  localparam int unsigned NEURONS_DEFAULT = 1024;

  // trace steps applied on a spike
  localparam logic [TR_W-1:0] LTP_STEP = 16'd6554;
  localparam logic [TR_W-1:0] LTD_STEP = 16'd7864;

  // fixed-point constants (Q12.8 voltages, Q0.16 coefficients)
  localparam logic signed [V_W-1:0] Q_REST          = -20'sd16640;
  localparam logic signed [V_W-1:0] Q_REST_RECOVERY = -20'sd3328;
  localparam logic signed [V_W-1:0] Q_THRESHOLD     = 20'sd7680;
  localparam logic signed [V_W-1:0] S20_MAX         = 20'sd524287;
  localparam logic signed [V_W-1:0] S20_MIN         = -20'sd524288;
  localparam logic [11:0]           Q_FOUR_HUNDREDTHS = 12'd2621;
  localparam logic [14:0]           Q_FIFTH           = 15'd13107;
  localparam logic signed [23:0]    Q_ONE_FORTY       = 24'sd35840;

  // register reset values
  localparam logic [NE_W-1:0]       NE_COUNT_RST    = 11'd800;
  localparam logic [COEF_W-1:0]     A_EXC_RST       = 16'd1311;
  localparam logic [COEF_W-1:0]     A_INH_RST       = 16'd6554;
  localparam logic [COEF_W-1:0]     D_EXC_RST       = 16'd2048;
  localparam logic [COEF_W-1:0]     D_INH_RST       = 16'd512;
  localparam logic signed [V_W-1:0] RESET_V_RST     = -20'sd16640;
  localparam logic [COEF_W-1:0]     TRACE_DECAY_RST = 16'd62339;

  // result queue sizing
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_PW    = 4;
  localparam int unsigned CNT_W      = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NE_COUNT      = 3'd0,
    CFG_A_EXC         = 3'd1,
    CFG_A_INH         = 3'd2,
    CFG_D_EXC         = 3'd3,
    CFG_D_INH         = 3'd4,
    CFG_RESET_VOLTAGE = 3'd5,
    CFG_TRACE_DECAY   = 3'd6
  } cfg_idx_e;

  // one result item
  typedef struct packed {
    logic [IDX_W-1:0]     neuron_id;
    logic                 fired;
    logic [V_W-1:0]       membrane;
    logic [TR_W-1:0]      ltp;
    logic [TR_W-1:0]      ltd;
  } result_t;

  // one state memory word
  typedef struct packed {
    logic [V_W-1:0]  v;
    logic [V_W-1:0]  u;
    logic [TR_W-1:0] ltp;
    logic [TR_W-1:0] ltd;
  } mem_word_t;

  // per-item context carried down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [V_W-1:0]    cur;
    logic              fired;
    logic [COEF_W-1:0] a;
    logic [V_W-1:0]    u;
    logic [TR_W-1:0]   ltp;
    logic [TR_W-1:0]   ltd;
    logic [TR_W-1:0]   ltp_dec;
    logic [TR_W-1:0]   ltd_dec;
  } ctx_t;

endpackage

// ===== sv/snu_ram.sv =====
// ----------------------------------------------------------------------------
// snu_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module snu_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/snu_fifo.sv =====
// ----------------------------------------------------------------------------
// snu_fifo
// Result queue between the update pipeline and the output channel.
// ----------------------------------------------------------------------------
module snu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  snu_pkg::result_t  push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output snu_pkg::result_t  data_o
);

  snu_pkg::result_t                 mem_q [snu_pkg::FIFO_DEPTH];
  logic [snu_pkg::FIFO_PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [snu_pkg::CNT_W-1:0]        count_q;
  logic                             pop;

  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== sv/spiking_neuron_update_with_stdp_traces_unit.sv =====
// Results: each item passes the update pipeline, then the result queue.
// Throughput: one item per cycle while successive items use different state entries
// and fewer than 16 items await delivery; an item whose state entry is still in the
// 11-stage update pipeline waits until that entry is written back.
// Reset: registers take their defaults at once; the state RAM is then cleared one
// entry a cycle up to entry NEURONS-1; no input item is taken while it clears.
// ----------------------------------------------------------------------------
// spiking_neuron_update_with_stdp_traces_unit
// One-tick update of a quadratic integrate-and-fire neuron with recovery and
// two plasticity traces, state held in one read-modify-write RAM.
// ----------------------------------------------------------------------------
module spiking_neuron_update_with_stdp_traces_unit #(
  parameter int unsigned NEURONS = snu_pkg::NEURONS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [snu_pkg::IDX_W-1:0]           neuron_index_i,
  input  logic signed [snu_pkg::V_W-1:0]      input_current_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [snu_pkg::IDX_W-1:0]           neuron_id_o,
  output logic                                fired_o,
  output logic signed [snu_pkg::V_W-1:0]      membrane_out_o,
  output logic [snu_pkg::TR_W-1:0]            potentiation_trace_o,
  output logic [snu_pkg::TR_W-1:0]            depression_trace_o,
  input  logic                                cfg_we_i,
  input  logic [snu_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [snu_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AW     = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned STAGES = 11;
  localparam int unsigned IDX_W  = snu_pkg::IDX_W;

  // --------------------------------------------------------------------------
  // arithmetic helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [19:0] sat20(input logic signed [27:0] x);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    hi = snu_pkg::S20_MAX;
    lo = snu_pkg::S20_MIN;
    if (x > hi) begin
      return snu_pkg::S20_MAX;
    end
    if (x < lo) begin
      return snu_pkg::S20_MIN;
    end
    return $signed(x[19:0]);
  endfunction

  // 5v + 140 - u + i
  function automatic logic signed [23:0] lin_term(input logic signed [19:0] v,
                                                  input logic signed [19:0] u,
                                                  input logic signed [19:0] cur);
    logic signed [23:0] vx;
    logic signed [23:0] ux;
    logic signed [23:0] cx;
    vx = v;
    ux = u;
    cx = cur;
    return (vx <<< 2) + vx + snu_pkg::Q_ONE_FORTY - ux + cx;
  endfunction

  // floor(v*v*0.04) in Q12.8
  function automatic logic [25:0] sq_scale(input logic [38:0] vv);
    logic [50:0] p;
    p = 51'(vv) * 51'(snu_pkg::Q_FOUR_HUNDREDTHS);
    return p[49:24];
  endfunction

  // v + floor(dv/2), saturated
  function automatic logic signed [19:0] half_finish(input logic signed [19:0] v,
                                                     input logic [25:0] sqs,
                                                     input logic signed [23:0] lin);
    logic signed [27:0] dv;
    logic signed [27:0] vx;
    logic signed [27:0] lx;
    vx = v;
    lx = lin;
    dv = $signed({2'b00, sqs}) + lx;
    return sat20(vx + (dv >>> 1));
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [snu_pkg::NE_W-1:0]         ne_count_q;
  logic [snu_pkg::COEF_W-1:0]       a_exc_q, a_inh_q, d_exc_q, d_inh_q, decay_q;
  logic signed [snu_pkg::V_W-1:0]   reset_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_count_q <= snu_pkg::NE_COUNT_RST;
      a_exc_q    <= snu_pkg::A_EXC_RST;
      a_inh_q    <= snu_pkg::A_INH_RST;
      d_exc_q    <= snu_pkg::D_EXC_RST;
      d_inh_q    <= snu_pkg::D_INH_RST;
      reset_v_q  <= snu_pkg::RESET_V_RST;
      decay_q    <= snu_pkg::TRACE_DECAY_RST;
    end else if (cfg_we_i) begin
      case (snu_pkg::cfg_idx_e'(cfg_index_i))
        snu_pkg::CFG_NE_COUNT:      ne_count_q <= cfg_data_i[snu_pkg::NE_W-1:0];
        snu_pkg::CFG_A_EXC:         a_exc_q    <= cfg_data_i[snu_pkg::COEF_W-1:0];
        snu_pkg::CFG_A_INH:         a_inh_q    <= cfg_data_i[snu_pkg::COEF_W-1:0];
        snu_pkg::CFG_D_EXC:         d_exc_q    <= cfg_data_i[snu_pkg::COEF_W-1:0];
        snu_pkg::CFG_D_INH:         d_inh_q    <= cfg_data_i[snu_pkg::COEF_W-1:0];
        snu_pkg::CFG_RESET_VOLTAGE: reset_v_q  <= $signed(cfg_data_i[snu_pkg::V_W-1:0]);
        snu_pkg::CFG_TRACE_DECAY:   decay_q    <= cfg_data_i[snu_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // state ram clearing pass after reset
  // --------------------------------------------------------------------------
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(NEURONS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // state entry of the incoming index (index modulo NEURONS)
  // --------------------------------------------------------------------------
  logic [AW-1:0] in_slot;

  if (NEURONS >= (1 << IDX_W)) begin : g_slot_direct
    assign in_slot = AW'(neuron_index_i);
  end else begin : g_slot_mod
    // reciprocal estimate, low by at most one, then one correction
    localparam int unsigned RECIP_SH = 20;
    localparam int unsigned RECIP    = (1 << RECIP_SH) / NEURONS;
    localparam int unsigned PW       = IDX_W + RECIP_SH + 1;
    logic [PW-1:0]    q_prod;
    logic [IDX_W-1:0] q_est;
    logic [IDX_W:0]   q_mul, rem, rem_fix;

    assign q_prod  = PW'(neuron_index_i) * PW'(RECIP);
    assign q_est   = q_prod[RECIP_SH +: IDX_W];
    assign q_mul   = (IDX_W + 1)'(q_est) * (IDX_W + 1)'(NEURONS);
    assign rem     = {1'b0, neuron_index_i} - q_mul;
    assign rem_fix = (rem >= (IDX_W + 1)'(NEURONS)) ? rem - (IDX_W + 1)'(NEURONS) : rem;
    assign in_slot = AW'(rem_fix);
  end

  // --------------------------------------------------------------------------
  // input handshake, interlock on entries still in flight
  // --------------------------------------------------------------------------
  logic [STAGES-1:0]         st_valid_q;
  logic [AW-1:0]             st_slot_q [STAGES];
  logic                      hazard;
  logic                      in_xfer, out_xfer;
  logic [snu_pkg::CNT_W-1:0] inflight_q;

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < STAGES; k++) begin
      if (st_valid_q[k] && (st_slot_q[k] == in_slot)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_ready_o = !clr_busy_q && !hazard &&
                      (inflight_q < snu_pkg::CNT_W'(snu_pkg::FIFO_DEPTH));
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_o && out_ready_i;

  // items accepted and not yet delivered, bounded by the result queue depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   inflight_q <= inflight_q + 1'b1;
        2'b01:   inflight_q <= inflight_q - 1'b1;
        default: inflight_q <= inflight_q;
      endcase
    end
  end

  // valid and entry shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else begin
      st_valid_q <= {st_valid_q[STAGES-2:0], in_xfer};
    end
  end

  always_ff @(posedge clk_i) begin
    st_slot_q[0] <= in_slot;
    for (int k = 1; k < STAGES; k++) begin
      st_slot_q[k] <= st_slot_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // state ram
  // --------------------------------------------------------------------------
  snu_pkg::mem_word_t rd_word, wb_word, rst_word, ram_wdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;

  assign rst_word = '{v: snu_pkg::Q_REST, u: snu_pkg::Q_REST_RECOVERY,
                      ltp: '0, ltd: '0};

  assign ram_we    = clr_busy_q || st_valid_q[STAGES-1];
  assign ram_waddr = clr_busy_q ? clr_addr_q : st_slot_q[STAGES-1];
  assign ram_wdata = clr_busy_q ? rst_word : wb_word;

  snu_ram #(
    .WIDTH  ($bits(snu_pkg::mem_word_t)),
    .DEPTH  (NEURONS),
    .ADDR_W (AW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (in_slot),
    .rdata_o (rd_word)
  );

  // --------------------------------------------------------------------------
  // stage 0: input payload, ram read in progress
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]               idx_s0_q;
  logic signed [snu_pkg::V_W-1:0] cur_s0_q;

  always_ff @(posedge clk_i) begin
    idx_s0_q <= neuron_index_i;
    cur_s0_q <= input_current_i;
  end

  // spike check, class select, spike reset and trace decay
  snu_pkg::ctx_t                  ctx_d;
  logic signed [snu_pkg::V_W-1:0] v_spk;
  logic                           is_exc, spike;
  logic signed [27:0]             u_jump_sum;
  logic [snu_pkg::COEF_W-1:0]     d_sel;
  logic [31:0]                    ltp_prod, ltd_prod;

  always_comb begin
    is_exc     = ({1'b0, idx_s0_q} < ne_count_q);
    spike      = ($signed(rd_word.v) >= snu_pkg::Q_THRESHOLD);
    d_sel      = is_exc ? d_exc_q : d_inh_q;
    u_jump_sum = 28'($signed(rd_word.u)) + $signed({12'd0, d_sel});
    v_spk      = spike ? reset_v_q : $signed(rd_word.v);

    ctx_d.idx   = idx_s0_q;
    ctx_d.cur   = cur_s0_q;
    ctx_d.fired = spike;
    ctx_d.a     = is_exc ? a_exc_q : a_inh_q;
    ctx_d.u     = spike ? sat20(u_jump_sum) : rd_word.u;
    ctx_d.ltp   = spike ? snu_pkg::LTP_STEP : rd_word.ltp;
    ctx_d.ltd   = spike ? snu_pkg::LTD_STEP : rd_word.ltd;

    ltp_prod      = 32'(ctx_d.ltp) * 32'(decay_q);
    ltd_prod      = 32'(ctx_d.ltd) * 32'(decay_q);
    ctx_d.ltp_dec = ltp_prod[31:16];
    ctx_d.ltd_dec = ltd_prod[31:16];
  end

  // context line for stages 1 to STAGES-1
  snu_pkg::ctx_t ctx_q [STAGES];

  always_ff @(posedge clk_i) begin
    ctx_q[0] <= ctx_d;
    for (int k = 1; k < STAGES; k++) begin
      ctx_q[k] <= ctx_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // first half step: square, scale, finish (stages 1 to 3)
  // --------------------------------------------------------------------------
  logic signed [snu_pkg::V_W-1:0] v_s1_q, v_s2_q, v_s3_q;
  logic [38:0]                    vv_s2_q;
  logic signed [23:0]             lin_s2_q, lin_s3_q;
  logic [25:0]                    sqs_s3_q;
  logic signed [39:0]             vv_a;

  assign vv_a = 40'(v_s1_q) * 40'(v_s1_q);

  always_ff @(posedge clk_i) begin
    v_s1_q   <= v_spk;
    vv_s2_q  <= vv_a[38:0];
    lin_s2_q <= lin_term(v_s1_q, $signed(ctx_q[0].u), $signed(ctx_q[0].cur));
    v_s2_q   <= v_s1_q;
    sqs_s3_q <= sq_scale(vv_s2_q);
    lin_s3_q <= lin_s2_q;
    v_s3_q   <= v_s2_q;
  end

  // --------------------------------------------------------------------------
  // second half step with the same recovery (stages 4 to 6)
  // --------------------------------------------------------------------------
  logic signed [snu_pkg::V_W-1:0] v_s4_q, v_s5_q, v_s6_q;
  logic [38:0]                    vv_s5_q;
  logic signed [23:0]             lin_s5_q, lin_s6_q;
  logic [25:0]                    sqs_s6_q;
  logic signed [39:0]             vv_b;

  assign vv_b = 40'(v_s4_q) * 40'(v_s4_q);

  always_ff @(posedge clk_i) begin
    v_s4_q   <= half_finish(v_s3_q, sqs_s3_q, lin_s3_q);
    vv_s5_q  <= vv_b[38:0];
    lin_s5_q <= lin_term(v_s4_q, $signed(ctx_q[3].u), $signed(ctx_q[3].cur));
    v_s5_q   <= v_s4_q;
    sqs_s6_q <= sq_scale(vv_s5_q);
    lin_s6_q <= lin_s5_q;
    v_s6_q   <= v_s5_q;
  end

  // --------------------------------------------------------------------------
  // recovery update (stages 7 to 10)
  // --------------------------------------------------------------------------
  logic signed [snu_pkg::V_W-1:0] v_s7_q, v_s8_q, v_s9_q, v_s10_q;
  logic signed [35:0]             wprod_s8_q;
  logic signed [21:0]             diff_s9_q;
  logic signed [38:0]             rprod_s10_q;
  logic signed [19:0]             w_val;
  logic signed [21:0]             diff_d;
  logic signed [27:0]             u_sum;

  assign w_val  = $signed(wprod_s8_q[35:16]);
  assign diff_d = 22'(w_val) - 22'($signed(ctx_q[7].u));
  assign u_sum  = 28'($signed(ctx_q[9].u)) + 28'($signed(rprod_s10_q[38:16]));

  always_ff @(posedge clk_i) begin
    v_s7_q      <= half_finish(v_s6_q, sqs_s6_q, lin_s6_q);
    wprod_s8_q  <= 36'(v_s7_q) * 36'($signed({1'b0, snu_pkg::Q_FIFTH}));
    v_s8_q      <= v_s7_q;
    diff_s9_q   <= diff_d;
    v_s9_q      <= v_s8_q;
    rprod_s10_q <= 39'($signed({1'b0, ctx_q[8].a})) * 39'(diff_s9_q);
    v_s10_q     <= v_s9_q;
  end

  // write-back word
  assign wb_word = '{v: v_s10_q, u: sat20(u_sum),
                     ltp: ctx_q[9].ltp_dec, ltd: ctx_q[9].ltd_dec};

  // --------------------------------------------------------------------------
  // result queue and output channel
  // --------------------------------------------------------------------------
  snu_pkg::result_t res_push, res_head;

  assign res_push = '{neuron_id: ctx_q[9].idx, fired: ctx_q[9].fired,
                      membrane: v_s10_q, ltp: ctx_q[9].ltp, ltd: ctx_q[9].ltd};

  snu_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (st_valid_q[STAGES-1]),
    .push_data_i (res_push),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (res_head)
  );

  assign neuron_id_o          = res_head.neuron_id;
  assign fired_o              = res_head.fired;
  assign membrane_out_o       = $signed(res_head.membrane);
  assign potentiation_trace_o = res_head.ltp;
  assign depression_trace_o   = res_head.ltd;

endmodule

// ===== tb/spiking_neuron_update_with_stdp_traces_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spiking_neuron_update_with_stdp_traces_unit_tb
// Drives neuron tick requests through the valid/ready input, keeps a shadow
// copy of every neuron's membrane, recovery and trace state, and checks each
// result transfer field by field against the predicted update. Register
// settings are changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module spiking_neuron_update_with_stdp_traces_unit_tb;

  // field widths
  localparam int unsigned IDX_W      = snu_pkg::IDX_W;
  localparam int unsigned V_W        = snu_pkg::V_W;
  localparam int unsigned TR_W       = snu_pkg::TR_W;
  localparam int unsigned COEF_W     = snu_pkg::COEF_W;
  localparam int unsigned NE_W       = snu_pkg::NE_W;
  localparam int unsigned CFG_IDX_W  = snu_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = snu_pkg::CFG_DATA_W;

  // fixed-point constants of the neuron equations
  localparam longint K_SQUARE    = 2621;   // 0.04 in Q0.16
  localparam longint K_FIFTH     = 13107;  // 0.2 in Q0.16
  localparam longint K_ONE_FORTY = 35840;  // 140 in Q12.8
  localparam int unsigned STATE_DEPTH = snu_pkg::NEURONS_DEFAULT;

  // run shape
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 255;
  localparam int unsigned QUIET_AFTER     = 1400;
  localparam int unsigned HOLD_AT         = 300;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned TAIL_CYCLES     = 24;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [IDX_W-1:0]       neuron_index_i = '0;
  logic signed [V_W-1:0]  input_current_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [IDX_W-1:0]       neuron_id_o;
  logic                   fired_o;
  logic signed [V_W-1:0]  membrane_out_o;
  logic [TR_W-1:0]        potentiation_trace_o;
  logic [TR_W-1:0]        depression_trace_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int unsigned items_sent = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_hold = 0;
  bit          hold_done = 1'b0;

  // shadow neuron state and expected updates
  class neuron_tick_scoreboard;
    logic signed [V_W-1:0] membrane [STATE_DEPTH];
    logic signed [V_W-1:0] recovery [STATE_DEPTH];
    logic [TR_W-1:0]       potentiation [STATE_DEPTH];
    logic [TR_W-1:0]       depression [STATE_DEPTH];
    logic [NE_W-1:0]       ne_count;
    logic [COEF_W-1:0]     a_exc, a_inh, d_exc, d_inh, decay;
    logic signed [V_W-1:0] reset_v;
    snu_pkg::result_t      expected_updates [$];
    int unsigned           mismatches;

    function new();
      ne_count = snu_pkg::NE_COUNT_RST;
      a_exc    = snu_pkg::A_EXC_RST;
      a_inh    = snu_pkg::A_INH_RST;
      d_exc    = snu_pkg::D_EXC_RST;
      d_inh    = snu_pkg::D_INH_RST;
      reset_v  = snu_pkg::RESET_V_RST;
      decay    = snu_pkg::TRACE_DECAY_RST;
      mismatches = 0;
      for (int i = 0; i < STATE_DEPTH; i++) begin
        membrane[i]     = snu_pkg::Q_REST;
        recovery[i]     = snu_pkg::Q_REST_RECOVERY;
        potentiation[i] = '0;
        depression[i]   = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        snu_pkg::CFG_NE_COUNT:      ne_count = data[NE_W-1:0];
        snu_pkg::CFG_A_EXC:         a_exc    = data[COEF_W-1:0];
        snu_pkg::CFG_A_INH:         a_inh    = data[COEF_W-1:0];
        snu_pkg::CFG_D_EXC:         d_exc    = data[COEF_W-1:0];
        snu_pkg::CFG_D_INH:         d_inh    = data[COEF_W-1:0];
        snu_pkg::CFG_RESET_VOLTAGE: reset_v  = $signed(data[V_W-1:0]);
        snu_pkg::CFG_TRACE_DECAY:   decay    = data[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp20(longint x);
      if (x < longint'(snu_pkg::S20_MIN)) return longint'(snu_pkg::S20_MIN);
      if (x > longint'(snu_pkg::S20_MAX)) return longint'(snu_pkg::S20_MAX);
      return x;
    endfunction

    // half a millisecond of membrane integration
    function longint half_step(longint v, longint u, longint cur);
      longint dv;
      dv = ((v * v * K_SQUARE) >>> 24) + 5 * v + K_ONE_FORTY - u + cur;
      return clamp20(v + (dv >>> 1));
    endfunction

    // one tick of one neuron, accepted at the input
    function void note_tick(logic [IDX_W-1:0] idx, logic signed [V_W-1:0] cur);
      longint           v, u, a, d, w, c;
      logic [TR_W-1:0]  p, q;
      logic [31:0]      prod;
      bit               exc, spike;
      int unsigned      slot;
      snu_pkg::result_t r;
      slot = 32'(idx) % STATE_DEPTH;
      v = longint'(membrane[slot]);
      u = longint'(recovery[slot]);
      p = potentiation[slot];
      q = depression[slot];
      c = longint'(cur);
      exc = ({1'b0, idx} < ne_count);
      a = longint'(exc ? a_exc : a_inh);
      d = longint'(exc ? d_exc : d_inh);
      spike = (v >= longint'(snu_pkg::Q_THRESHOLD));
      // spike: reset membrane, bump recovery, set both traces
      if (spike) begin
        v = longint'(reset_v);
        u = clamp20(u + d);
        p = snu_pkg::LTP_STEP;
        q = snu_pkg::LTD_STEP;
      end
      v = half_step(v, u, c);
      v = half_step(v, u, c);
      w = (v * K_FIFTH) >>> 16;
      u = clamp20(u + ((a * (w - u)) >>> 16));
      membrane[slot] = $signed(v[V_W-1:0]);
      recovery[slot] = $signed(u[V_W-1:0]);
      prod = 32'(p) * 32'(decay);
      potentiation[slot] = prod[31:16];
      prod = 32'(q) * 32'(decay);
      depression[slot] = prod[31:16];
      r.neuron_id = idx;
      r.fired     = spike;
      r.membrane  = v[V_W-1:0];
      r.ltp       = p;
      r.ltd       = q;
      expected_updates.push_back(r);
    endfunction

    function void compare_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    // one result transfer against the oldest expectation
    function void check_update(logic [IDX_W-1:0] id, logic fired, logic signed [V_W-1:0] mem,
                               logic [TR_W-1:0] ltp, logic [TR_W-1:0] ltd);
      snu_pkg::result_t e;
      if (expected_updates.size() == 0) begin
        $error("result for neuron %0d with no update expected", id);
        mismatches++;
        return;
      end
      e = expected_updates.pop_front();
      compare_field("neuron_id", longint'(e.neuron_id), longint'(id));
      compare_field("fired", longint'(e.fired), longint'(fired));
      compare_field("membrane_out", longint'($signed(e.membrane)), longint'(mem));
      compare_field("potentiation_trace", longint'(e.ltp), longint'(ltp));
      compare_field("depression_trace", longint'(e.ltd), longint'(ltd));
    endfunction
  endclass

  neuron_tick_scoreboard sb = new();

  spiking_neuron_update_with_stdp_traces_unit DUT (.*);

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // idling allowed except in every fourth stretch of 128 and near the end
  function automatic bit idling_on(int unsigned n);
    return (n < QUIET_AFTER) && ((n / 128) % 4 != 3);
  endfunction

  // result receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (sink_hold != 0) begin
      out_ready_i <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!hold_done && results_taken >= HOLD_AT) begin
      out_ready_i <= 1'b0;
      hold_done <= 1'b1;
      sink_hold <= HOLD_CYCLES - 1;
    end else if (sink_gap != 0) begin
      out_ready_i <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (idling_on(results_taken) && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      sink_gap <= $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result monitor and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_update(neuron_id_o, fired_o, membrane_out_o,
                        potentiation_trace_o, depression_trace_o);
        results_taken++;
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // offer one tick request and wait for its transfer
  task automatic send_tick(input logic [IDX_W-1:0] idx, input logic signed [V_W-1:0] cur);
    bit taken;
    if (idling_on(items_sent) && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    neuron_index_i  <= idx;
    input_current_i <= cur;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    sb.note_tick(idx, cur);
    items_sent++;
  endtask

  // mostly a few busy neurons with moderate current, so they integrate and fire
  task automatic random_tick();
    int unsigned           pick;
    logic [IDX_W-1:0]      idx;
    logic signed [V_W-1:0] cur;
    pick = $urandom_range(0, 9);
    if (pick < 4) idx = IDX_W'($urandom_range(0, 7));
    else if (pick < 6) idx = IDX_W'(int'(sb.ne_count) + int'($urandom_range(0, 7)) - 4);
    else idx = IDX_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 19);
    if (pick < 12) cur = V_W'(int'($urandom_range(0, 7680)) - 2560);
    else if (pick < 17) cur = V_W'(int'($urandom_range(0, 51200)) - 25600);
    else cur = V_W'($urandom());
    send_tick(idx, cur);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_register(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] ne, a_e, a_i, d_e, d_i, rv, dec);
    write_register(snu_pkg::CFG_NE_COUNT, ne);
    write_register(snu_pkg::CFG_A_EXC, a_e);
    write_register(snu_pkg::CFG_A_INH, a_i);
    write_register(snu_pkg::CFG_D_EXC, d_e);
    write_register(snu_pkg::CFG_D_INH, d_i);
    write_register(snu_pkg::CFG_RESET_VOLTAGE, rv);
    write_register(snu_pkg::CFG_TRACE_DECAY, dec);
    // a write to the unused index must leave every register alone
    write_register(CFG_SPARE, CFG_DATA_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, saturation, firing on both sides of the class boundary
    send_tick(10'd0, 20'sd0);
    send_tick(10'd1023, snu_pkg::S20_MAX);
    send_tick(10'd1, snu_pkg::S20_MIN);
    send_tick(10'd1023, 20'sd0);
    send_tick(10'd1, 20'sd0);
    send_tick(10'd799, snu_pkg::S20_MAX);
    send_tick(10'd799, 20'sd0);
    send_tick(10'd800, snu_pkg::S20_MAX);
    send_tick(10'd800, 20'sd0);
    send_tick(10'd5, 20'sd2560);
    send_tick(10'd5, 20'sd2560);
    send_tick(10'd5, 20'sd2560);
    for (int i = 0; i < 6; i++) send_tick(10'd6, 20'sd5120);
    send_tick(10'd341, 20'sh55555);
    send_tick(10'd682, 20'shAAAAA);
    send_tick(10'd1023, -20'sd1);
    send_tick(10'd0, 20'sd1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      while (sb.expected_updates.size() != 0) @(posedge clk_i);
      case (ph)
        0: apply_settings(CFG_DATA_W'(snu_pkg::NE_COUNT_RST), CFG_DATA_W'(snu_pkg::A_EXC_RST),
                          CFG_DATA_W'(snu_pkg::A_INH_RST), CFG_DATA_W'(snu_pkg::D_EXC_RST),
                          CFG_DATA_W'(snu_pkg::D_INH_RST), snu_pkg::RESET_V_RST,
                          CFG_DATA_W'(snu_pkg::TRACE_DECAY_RST));
        1: apply_settings(20'd2047, 20'd65535, 20'd65535, 20'd65535, 20'd65535,
                          snu_pkg::S20_MAX, 20'd65535);
        2: apply_settings(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, snu_pkg::S20_MIN, 20'd0);
        3: apply_settings(20'd1024, 20'd65535, 20'd0, 20'd0, 20'd65535, snu_pkg::Q_REST,
                          20'd32768);
        4: apply_settings(CFG_DATA_W'($urandom_range(0, 2047)),
                          CFG_DATA_W'($urandom_range(0, 65535)),
                          CFG_DATA_W'($urandom_range(0, 65535)),
                          CFG_DATA_W'($urandom_range(0, 4096)),
                          CFG_DATA_W'($urandom_range(0, 4096)),
                          V_W'(-256 * int'($urandom_range(40, 80))),
                          CFG_DATA_W'($urandom_range(0, 65535)));
        default: apply_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                CFG_DATA_W'($urandom()));
      endcase
      repeat (ITEMS_PER_PHASE) random_tick();
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (sb.expected_updates.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_updates.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== spiking_neuron_update_with_stdp_traces_unit.f =====
sv/snu_pkg.sv
sv/snu_ram.sv
sv/snu_fifo.sv
sv/spiking_neuron_update_with_stdp_traces_unit.sv
tb/spiking_neuron_update_with_stdp_traces_unit_tb.sv
